/* design/ctg_pkg.sv */
package ctg_pkg;

  localparam int MaxK = 8;
  localparam int MaxN = 16;
  localparam int KW = 4;   // index width for slots
  localparam int PW = 3;   // position width

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_PERM  = 2'd0,
    MODE_ARR   = 2'd1,
    MODE_COMB  = 2'd2,
    MODE_COMBR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_LEN  = 2'd1,
    CFG_SIZE = 2'd2
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_FILL,
    ST_EMIT,
    ST_EXH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic rewind;
    logic first;      // build the first tuple
    logic step;       // one backward scan step
    logic fill;       // one forward fill step
    logic emit_load;  // load output register with current position
    logic exh_load;   // load the exhausted result
    logic count;      // bump tuple counter
    logic set_fin;
    logic set_start;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic started;
    logic finished;
    logic first_ok;
    logic step_found;  // current scan position advanced
    logic step_end;    // scan fell off position 0
    logic fill_done;
    logic emit_last;
    logic out_busy;    // output register holds an untaken result, or one is pending
  } sts_t;

endpackage

/* design/ctg_ram.sv */
module ctg_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* design/ctg_ctrl.sv */
module ctg_ctrl import ctg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,     // advance transfer accepted
  input  logic  cfg_hit, // rewind request (restart or mode/length/size cfg write)
  input  sts_t  sts,
  output cmd_t  cmd,
  output logic  busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rewind = cfg_hit;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (adv) begin
          if (sts.finished) state_next = ST_EXH;
          else if (!sts.started) begin
            cmd.first = 1'b1;
            cmd.set_start = 1'b1;
            state_next = sts.first_ok ? ST_EMIT : ST_EXH;
            if (!sts.first_ok) cmd.set_fin = 1'b1;
            else cmd.count = 1'b1;
          end else state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (sts.step_end) begin
          cmd.set_fin = 1'b1;
          state_next = ST_EXH;
        end else if (sts.step_found) begin
          cmd.count = 1'b1;
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) state_next = ST_IDLE;
        end
      end
      ST_EXH: begin
        if (!sts.out_busy) begin
          cmd.exh_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

/* design/ctg_dp.sv */
module ctg_dp import ctg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [1:0]        mode,
  input  logic [KW:0]       kq,     // effective k, 1..MaxK
  input  logic [KW:0]       nq,     // effective n, 0..MaxN
  // store access
  input  logic              ld_we,
  input  logic [KW-1:0]     ld_idx,
  input  logic signed [31:0] ld_val,
  // output register
  input  logic              out_stall,
  output logic              out_valid,
  output logic [PW-1:0]     position,
  output logic [KW-1:0]     chosen_index,
  output logic signed [31:0] chosen_value,
  output logic              last,
  output logic              exhausted,
  output logic [31:0]       tuple_ordinal
);
  logic [KW-1:0] pidx [MaxK];
  logic [MaxN-1:0] used;
  logic started, finished;
  logic [31:0] cnt;
  logic [PW:0] cur;    // scan / fill / emit position
  logic [PW:0] cur_next;

  // valid pending emission pipeline: RAM read is registered
  logic pend, pend_last;
  logic [PW-1:0] pend_pos;
  logic [KW-1:0] pend_idx;
  logic pend_exh;
  logic [31:0] rdata;

  ctg_ram #(.Width(32), .Depth(MaxN)) u_ram (
    .clk(clk), .we(ld_we), .waddr(ld_idx), .wdata(ld_val),
    .raddr(pidx[cur[PW-1:0]]), .rdata(rdata)
  );

  // scan step helpers
  logic [KW-1:0] ci;
  logic [KW:0] ci1;
  logic [MaxN-1:0] used_cl;
  logic [KW:0] free_hi, free_lo;
  logic ok_step;
  logic [KW:0] k_m1;

  assign k_m1 = kq - 1'b1;
  assign ci = pidx[cur[PW-1:0]];
  assign ci1 = {1'b0, ci} + 1'b1;

  always_comb begin
    used_cl = used & ~(MaxN'(1) << ci);
    free_hi = nq;
    free_lo = nq;
    for (int v = MaxN - 1; v >= 0; v--) begin
      // step: next free slot above the current one, current slot released
      if (v < nq && !used_cl[v] && (KW+1)'(v) >= ci1) free_hi = (KW+1)'(v);
      // fill: lowest free slot, current slot still held
      if (v < nq && !used[v]) free_lo = (KW+1)'(v);
    end
    unique case (mode_t'(mode))
      MODE_PERM: ok_step = free_hi < nq;
      MODE_COMB: ok_step = (ci1 + k_m1) < (nq + {1'b0, cur});
      default:   ok_step = ci1 < nq;
    endcase
  end

  logic first_ok;
  assign first_ok = (nq != 0) &&
    !((mode == MODE_PERM || mode == MODE_COMB) && kq > nq);

  // used mask of the first permutation
  logic [MaxN-1:0] first_used;
  always_comb begin
    first_used = '0;
    for (int i = 0; i < MaxK; i++)
      if (mode == MODE_PERM && first_ok && i < kq) first_used[i] = 1'b1;
  end

  logic out_busy;
  assign out_busy = (out_valid && out_stall) || pend;

  always_comb begin
    sts = '0;
    sts.started = started;
    sts.finished = finished;
    sts.first_ok = first_ok;
    sts.step_found = ok_step;
    sts.step_end = !ok_step && (cur == 0);
    sts.fill_done = (cur >= {1'b0, k_m1[PW:0]}) || (cur + 1'b1 >= (PW+1)'(kq));
    sts.emit_last = (cur + 1'b1 == (PW+1)'(kq)) || (kq == (KW+1)'(MaxK) && cur == (PW+1)'(MaxK-1));
    sts.out_busy = out_busy;
  end

  // index state
  always_ff @(posedge clk) begin
    if (rst || cmd.rewind) begin
      for (int i = 0; i < MaxK; i++) pidx[i] <= '0;
      used <= '0;
      started <= 1'b0;
      finished <= 1'b0;
      cnt <= '0;
      cur <= '0;
    end else begin
      if (cmd.set_start) started <= 1'b1;
      if (cmd.set_fin) finished <= 1'b1;
      if (cmd.count && cnt != 32'hFFFF_FFFF) cnt <= cnt + 1'b1;
      cur <= cur_next;
      if (cmd.first) begin
        used <= first_used;
        for (int i = 0; i < MaxK; i++)
          pidx[i] <= (mode == MODE_PERM || mode == MODE_COMB) ? KW'(i) : '0;
      end
      if (cmd.step) begin
        if (mode == MODE_PERM) begin
          if (ok_step) used <= used_cl | (MaxN'(1) << free_hi[KW-1:0]);
          else used <= used_cl;
        end
        if (ok_step) pidx[cur[PW-1:0]] <= (mode == MODE_PERM) ? free_hi[KW-1:0] : ci1[KW-1:0];
        else if (mode == MODE_ARR) pidx[cur[PW-1:0]] <= '0;
      end
      if (cmd.fill && !sts.fill_done) begin
        unique case (mode_t'(mode))
          MODE_PERM: begin
            pidx[cur[PW-1:0] + 1'b1] <= (free_lo < nq) ? free_lo[KW-1:0] : '0;
            used <= used | ((free_lo < nq) ? (MaxN'(1) << free_lo[KW-1:0]) : MaxN'(1));
          end
          MODE_COMB:  pidx[cur[PW-1:0] + 1'b1] <= ci + 1'b1;
          MODE_COMBR: pidx[cur[PW-1:0] + 1'b1] <= ci;
          default:    pidx[cur[PW-1:0] + 1'b1] <= pidx[cur[PW-1:0] + 1'b1];
        endcase
      end
    end
  end

  // position pointer
  always_comb begin
    cur_next = cur;
    if (cmd.first) cur_next = '0;
    else if (cmd.step) begin
      if (ok_step) cur_next = cur;
      else if (cur != 0) cur_next = cur - 1'b1;
    end else if (cmd.fill) begin
      if (sts.fill_done) cur_next = '0;
      else cur_next = cur + 1'b1;
    end else if (cmd.emit_load) begin
      if (sts.emit_last) cur_next = (PW+1)'(k_m1);
      else cur_next = cur + 1'b1;
    end else if (cmd.exh_load) cur_next = (PW+1)'(k_m1);
  end

  // output register fed through the registered RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.emit_load || cmd.exh_load;
      if (pend) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load || cmd.exh_load) begin
      pend_exh <= cmd.exh_load;
      pend_pos <= cur[PW-1:0];
      pend_idx <= ci;
      pend_last <= cmd.exh_load || sts.emit_last;
    end
    if (pend) begin
      position <= pend_exh ? '0 : pend_pos;
      chosen_index <= pend_exh ? '0 : pend_idx;
      chosen_value <= pend_exh ? '0 : rdata;
      last <= pend_last;
      exhausted <= pend_exh;
      tuple_ordinal <= pend_exh ? '0 : cnt;
    end
  end
endmodule

/* design/combinatorial_tuple_generator.sv */
// Channel | Direction | Signals
// in      | input     | in_valid, in_stall, req_type, elem_index, elem_value
// out     | output    | out_valid, out_stall, position, chosen_index, chosen_value,
//         |           | last, exhausted, tuple_ordinal
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
// Load and restart take effect when accepted. An advance builds the first tuple, or runs
// backward scan steps and then forward fill steps, then emits each position through
// the set RAM's registered read and the output register; exhausted takes the same path.
// Reset is synchronous and clears all control and enumeration state.
// out_stall holds the output register; the sequencer waits on it.
module combinatorial_tuple_generator import ctg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [3:0]         elem_index,
  input  logic signed [31:0] elem_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         position,
  output logic [3:0]         chosen_index,
  output logic signed [31:0] chosen_value,
  output logic               last,
  output logic               exhausted,
  output logic [31:0]        tuple_ordinal,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic [1:0] mode;
  logic [3:0] tlen;
  logic [4:0] ssize;
  logic [KW:0] kq, nq;
  cmd_t cmd;
  sts_t sts;
  logic busy, acc, adv, cfg_we, rew;

  assign in_stall = busy;
  assign cfg_ready = 1'b1;
  assign acc = in_valid && !in_stall;
  assign adv = acc && req_type == REQ_ADVANCE;
  assign cfg_we = cfg_valid && cfg_ready;
  assign rew = (acc && req_type == REQ_RESTART) ||
               (cfg_we && (cfg_index == CFG_MODE || cfg_index == CFG_LEN ||
                cfg_index == CFG_SIZE));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PERM;
      tlen <= 4'd1;
      ssize <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_t'(cfg_index))
        CFG_MODE: mode <= cfg_data[1:0];
        CFG_LEN:  tlen <= cfg_data[3:0];
        CFG_SIZE: ssize <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective k and n
  assign kq = (tlen == 0) ? 5'd1 : (tlen > MaxK) ? 5'(MaxK) : {1'b0, tlen};
  assign nq = (ssize > MaxN) ? 5'(MaxN) : ssize;

  ctg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .adv(adv), .cfg_hit(rew), .sts(sts), .cmd(cmd), .busy(busy)
  );

  ctg_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .mode(mode), .kq(kq), .nq(nq),
    .ld_we(acc && req_type == REQ_LOAD), .ld_idx(elem_index), .ld_val(elem_value),
    .out_stall(out_stall), .out_valid(out_valid), .position(position),
    .chosen_index(chosen_index), .chosen_value(chosen_value), .last(last),
    .exhausted(exhausted), .tuple_ordinal(tuple_ordinal)
  );

  // no input taken while a tuple is in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("input taken while busy");
  // exhausted results are always last
  a_exh: assert property (@(posedge clk) disable iff (rst)
    (out_valid && exhausted) |-> last) else $error("exhausted without last");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(chosen_index))
    else $error("stalled output changed");
endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ctg_pkg::*;

  // one result transfer
  typedef struct packed {
    logic [2:0]         pos;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               lst;
    logic               exh;
    logic [31:0]        ord;
  } tuple_elem_t;

  // scoreboard: tuple enumerator predictor plus queue of pending elements
  class tuple_scoreboard;
    logic [31:0] slot_val [MaxN];
    logic [3:0]  pick [MaxK];
    logic [15:0] used_mask;
    bit          began, done;
    logic [31:0] ord_cnt;
    mode_t       mode;
    logic [3:0]  len_reg;
    logic [4:0]  size_reg;
    tuple_elem_t pending_q[$];
    int          errors, n_elems, n_exh;

    function void rewind();
      foreach (pick[i]) pick[i] = '0;
      used_mask = '0;
      began = 0;
      done = 0;
      ord_cnt = '0;
    endfunction

    function void reset_state();
      foreach (slot_val[i]) slot_val[i] = '0;
      mode = MODE_PERM;
      len_reg = 4'd1;
      size_reg = 5'd1;
      rewind();
    endfunction

    function void write_reg(cfg_t ri, logic [31:0] d);
      case (ri)
        CFG_MODE: mode = mode_t'(d[1:0]);
        CFG_LEN:  len_reg = d[3:0];
        CFG_SIZE: size_reg = d[4:0];
        default:  return;
      endcase
      rewind();
    endfunction

    function int lowest_free(int lo, int n);
      for (int v = lo; v < n; v++)
        if (!used_mask[v]) return v;
      return n;
    endfunction

    function bit first_tuple(int k, int n);
      used_mask = '0;
      if (n == 0) return 0;
      if ((mode == MODE_PERM || mode == MODE_COMB) && k > n) return 0;
      for (int i = 0; i < k; i++) begin
        pick[i] = (mode == MODE_PERM || mode == MODE_COMB) ? i[3:0] : 4'd0;
        if (mode == MODE_PERM) used_mask[i] = 1'b1;
      end
      return 1;
    endfunction

    function bit next_tuple(int k, int n);
      int v, w;
      case (mode)
        MODE_ARR: begin
          for (int i = k - 1; i >= 0; i--) begin
            if (pick[i] + 1 < n) begin
              pick[i]++;
              return 1;
            end
            pick[i] = '0;
          end
        end
        MODE_COMBR: begin
          for (int i = k - 1; i >= 0; i--)
            if (pick[i] + 1 < n) begin
              pick[i]++;
              for (int j = i + 1; j < k; j++) pick[j] = pick[i];
              return 1;
            end
        end
        MODE_COMB: begin
          for (int i = k - 1; i >= 0; i--)
            if (pick[i] + k < n + i) begin
              pick[i]++;
              for (int j = i + 1; j < k; j++) pick[j] = pick[j-1] + 4'd1;
              return 1;
            end
        end
        default: begin
          for (int i = k - 1; i >= 0; i--) begin
            used_mask[pick[i]] = 1'b0;
            v = lowest_free(pick[i] + 1, n);
            if (v < n) begin
              pick[i] = v[3:0];
              used_mask[v] = 1'b1;
              for (int j = i + 1; j < k; j++) begin
                w = lowest_free(0, n);
                if (w >= n) w = 0;
                pick[j] = w[3:0];
                used_mask[w] = 1'b1;
              end
              return 1;
            end
          end
        end
      endcase
      return 0;
    endfunction

    // note an accepted input transfer
    function void note_request(req_t r, logic [3:0] ei, logic [31:0] ev);
      int k, n;
      bit ok;
      tuple_elem_t e;
      k = (len_reg == 0) ? 1 : (len_reg > MaxK ? MaxK : len_reg);
      n = (size_reg > MaxN) ? MaxN : size_reg;
      case (r)
        REQ_LOAD:    slot_val[ei] = ev;
        REQ_RESTART: rewind();
        REQ_ADVANCE: begin
          ok = 0;
          if (!done) begin
            ok = began ? next_tuple(k, n) : first_tuple(k, n);
            began = 1;
            if (!ok) done = 1;
          end
          if (!ok) begin
            e = '0;
            e.lst = 1;
            e.exh = 1;
            pending_q.push_back(e);
            n_exh++;
          end else begin
            if (ord_cnt != 32'hFFFF_FFFF) ord_cnt++;
            for (int j = 0; j < k; j++) begin
              e.pos = j[2:0];
              e.idx = pick[j];
              e.val = slot_val[pick[j]];
              e.lst = (j == k - 1);
              e.exh = 0;
              e.ord = ord_cnt;
              pending_q.push_back(e);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // check an accepted result transfer
    function void check_elem(tuple_elem_t got);
      tuple_elem_t want;
      n_elems++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.pos !== want.pos)
        $display("%0t: position exp %0d got %0d", $time, want.pos, got.pos);
      if (got.idx !== want.idx)
        $display("%0t: chosen_index exp %0d got %0d", $time, want.idx, got.idx);
      if (got.val !== want.val)
        $display("%0t: chosen_value exp %0d got %0d", $time, want.val, got.val);
      if (got.lst !== want.lst)
        $display("%0t: last exp %0b got %0b", $time, want.lst, got.lst);
      if (got.exh !== want.exh)
        $display("%0t: exhausted exp %0b got %0b", $time, want.exh, got.exh);
      if (got.ord !== want.ord)
        $display("%0t: tuple_ordinal exp %0d got %0d", $time, want.ord, got.ord);
      if (got !== want) errors++;
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         req_type = '0;
  logic [3:0]         elem_index = '0;
  logic signed [31:0] elem_value = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [2:0]         position;
  logic [3:0]         chosen_index;
  logic signed [31:0] chosen_value;
  logic               last, exhausted;
  logic [31:0]        tuple_ordinal;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  tuple_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_items = 0;

  always #5 clk = ~clk;

  combinatorial_tuple_generator dut (.*);

  // result sampling and receiver stalls
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_elem({position, chosen_index, chosen_value, last, exhausted, tuple_ordinal});
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // valid stays up after a transfer until a pause, a drain or a hold-off takes it down
  task automatic send_req(req_t r, logic [3:0] ei, logic [31:0] ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    req_type <= r;
    elem_index <= ei;
    elem_value <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r, ei, ev);
    n_items++;
  endtask

  // wait until all results are back, then for the tail of any running advance
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (sb.pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(cfg_t ri, logic [31:0] d);
    drain();
    cfg_valid <= 1;
    cfg_index <= ri;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(ri, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_cfg(mode_t m, int k, int n);
    write_reg(CFG_MODE, {30'd0, m});
    write_reg(CFG_LEN, k);
    write_reg(CFG_SIZE, n);
  endtask

  task automatic advance();
    send_req(REQ_ADVANCE, 4'($urandom), $urandom);
  endtask

  task automatic load_all();
    for (int i = 0; i < MaxN; i++) send_req(REQ_LOAD, i[3:0], $urandom);
  endtask

  initial begin
    int ph, k, n;
    mode_t m;
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extreme values, every slot loaded
    send_req(REQ_LOAD, 4'd0, 32'h8000_0000);
    send_req(REQ_LOAD, 4'd15, 32'h7FFF_FFFF);
    send_req(REQ_LOAD, 4'd1, 32'hFFFF_FFFF);
    for (int i = 2; i < 15; i++) send_req(REQ_LOAD, i[3:0], i);
    advance();
    advance();  // N=1, k=1 perm: exhausted
    advance();
    send_req(REQ_NONE, 4'd3, 32'd5);
    send_req(REQ_RESTART, 4'd0, 0);
    advance();
    // too few elements, size 0, out of range length and size, unknown register
    set_cfg(MODE_COMB, 3, 2);
    advance();
    write_reg(CFG_SIZE, 0);
    advance();
    write_reg(CFG_LEN, 0);
    write_reg(CFG_SIZE, 31);
    advance();
    write_reg(cfg_t'(2'd3), 32'hFFFF_FFFF);
    advance();
    write_reg(CFG_LEN, 15);
    advance();
    // load during enumeration keeps indices
    send_req(REQ_LOAD, 4'd15, 32'h1234_5678);
    advance();

    // random phases over all modes and idling patterns
    for (ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      m = mode_t'(ph[1:0] ^ ph[3:2]);
      k = (ph == 5) ? 8 : $urandom_range(1, 4);
      n = (ph == 6) ? 16 : (ph == 7 ? 1 : $urandom_range(1, 5));
      set_cfg(m, k, n);
      if (ph == 0) load_all();
      for (int i = 0; i < 20; i++) begin
        case ($urandom_range(19))
          0: send_req(REQ_LOAD, 4'($urandom), $urandom);
          1: send_req(REQ_RESTART, 4'($urandom), $urandom);
          2: send_req(REQ_NONE, 4'($urandom), $urandom);
          default: advance();
        endcase
        // one hold-off until every result is back
        if (ph == 3 && i == 10) begin
          in_valid <= 0;
          @(posedge clk);
          while (sb.pending_q.size() != 0) @(posedge clk);
        end
      end
    end

    stall_pct = 0;
    drain();
    $display("Covered %0d input transfers, %0d results, %0d exhausted, four modes.",
             n_items, sb.n_elems, sb.n_exh);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb NOT OK");
    $finish;
  end
endmodule

/* sim.f */
design/ctg_pkg.sv
design/ctg_ram.sv
design/ctg_ctrl.sv
design/ctg_dp.sv
design/combinatorial_tuple_generator.sv
test/tb.sv
